// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== sv/hbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbd_pkg
// Types and constants of the Huffman tree-walk decoder.
// ----------------------------------------------------------------------------
package hbd_pkg;

	localparam int NODE_COUNT  = 512;
	localparam int IDX_W       = $clog2(NODE_COUNT);
	localparam int SYMBOL_BITS = 8;
	localparam int OUT_W       = 8;
	localparam int FIELD_IDX_W = 9;

	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		idx_t                   left;
		idx_t                   right;
		logic                   leaf;
		logic [SYMBOL_BITS-1:0] sym;
	} node_t;

	typedef struct packed {
		logic  is_load;
		idx_t  addr;
		node_t node;
		logic  code_bit;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_FETCH_NODE,
		ST_FETCH_ROOT_KIDS,
		ST_FETCH_CUR_KIDS
	} walk_state_t;

endpackage

// ===== sv/hbd_front.sv =====
// ----------------------------------------------------------------------------
// hbd_front
// Input stage: registers each transfer and classifies it as load or decode.
// ----------------------------------------------------------------------------
module hbd_front import hbd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   cmd,
	input  logic [FIELD_IDX_W-1:0] node_addr,
	input  logic [FIELD_IDX_W-1:0] left_child,
	input  logic [FIELD_IDX_W-1:0] right_child,
	input  logic                   leaf_flag,
	input  logic [7:0]             leaf_symbol,
	input  logic                   code_bit,
	input  fifo_status_t           fifo_st,
	output logic                   op_valid,
	output op_t                    op
);

	logic valid_s1;
	op_t  op_s1;
	logic accept;

	assign in_stall = valid_s1 && fifo_st.full;
	assign accept   = in_valid && !in_stall;
	assign op_valid = valid_s1;
	assign op       = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1.is_load    <= (cmd == CMD_LOAD);
			op_s1.addr       <= node_addr[IDX_W-1:0];
			op_s1.node.left  <= left_child[IDX_W-1:0];
			op_s1.node.right <= right_child[IDX_W-1:0];
			op_s1.node.leaf  <= leaf_flag;
			op_s1.node.sym   <= leaf_symbol[SYMBOL_BITS-1:0];
			op_s1.code_bit   <= code_bit;
		end
	end

endmodule

// ===== sv/hbd_fifo.sv =====
// ----------------------------------------------------------------------------
// hbd_fifo
// Short queue of classified items between the front and the tree walker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbd_fifo import hbd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	input  op_t          push_op,
	input  logic         pop,
	output op_t          head,
	output fifo_status_t st
);

	op_t                   fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  push;

	assign st.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign st.empty = (cnt_q == '0);
	assign push     = push_valid && !st.full;
	assign head     = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_op;
		end
	end

	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && st.empty)
	`ASSERT_PROP(a_cnt_range, clk, arst_n, cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
	`ASSERT_PROP(a_full_holds, clk, arst_n, (st.full && !pop) |=> st.full)

endmodule

// ===== sv/hbd_back.sv =====
// ----------------------------------------------------------------------------
// hbd_back
// Tree walker: node table, cached current/child/root entries, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbd_back import hbd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  op_t                head,
	input  fifo_status_t       fifo_st,
	output logic               pop,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [IDX_W-1:0]   root_node,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [OUT_W-1:0]   decoded_symbol
);

	node_t mem [NODE_COUNT];

	walk_state_t            state_q, state_d;
	logic                   stale_q;
	idx_t                   root_q;
	idx_t                   walk_q;
	logic                   kids_mem_q;
	node_t                  cur_q;
	node_t                  root_ent_q;
	node_t                  rl_q, rr_q;
	node_t                  rd_a_q, rd_b_q;
	logic                   out_valid_q;
	logic [SYMBOL_BITS-1:0] out_sym_q;

	logic                   cfg_we;
	logic                   out_free;
	node_t                  kid_l, kid_r, nxt;
	idx_t                   child;
	logic                   we;
	logic                   re_a, re_b;
	idx_t                   ra, rb;
	logic                   emit;
	logic [SYMBOL_BITS-1:0] emit_sym;
	logic                   restart;
	logic                   move;

	assign cfg_ready      = (state_q == ST_RUN);
	assign cfg_we         = cfg_valid && cfg_ready;
	assign out_free       = !out_valid_q || !out_stall;
	assign kid_l          = kids_mem_q ? rd_a_q : rl_q;
	assign kid_r          = kids_mem_q ? rd_b_q : rr_q;
	assign nxt            = head.code_bit ? kid_r : kid_l;
	assign child          = head.code_bit ? cur_q.right : cur_q.left;
	assign out_valid      = out_valid_q;
	assign decoded_symbol = OUT_W'(out_sym_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (!cfg_we && !fifo_st.empty && !head.is_load && stale_q) begin
					state_d = ST_FETCH_NODE;
				end
			end
			ST_FETCH_NODE:      state_d = ST_FETCH_ROOT_KIDS;
			ST_FETCH_ROOT_KIDS: state_d = ST_FETCH_CUR_KIDS;
			ST_FETCH_CUR_KIDS:  state_d = ST_RUN;
			default:            state_d = ST_RUN;
		endcase
	end

	// outputs
	always_comb begin
		pop      = 1'b0;
		we       = 1'b0;
		re_a     = 1'b0;
		re_b     = 1'b0;
		ra       = '0;
		rb       = '0;
		emit     = 1'b0;
		emit_sym = '0;
		restart  = 1'b0;
		move     = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				if (!cfg_we && !fifo_st.empty) begin
					if (head.is_load) begin
						pop = 1'b1;
						we  = 1'b1;
					end else if (!stale_q && out_free) begin
						pop = 1'b1;
						if (cur_q.leaf) begin
							emit     = 1'b1;
							emit_sym = cur_q.sym;
							restart  = 1'b1;
						end else if (nxt.leaf) begin
							emit     = 1'b1;
							emit_sym = nxt.sym;
							restart  = 1'b1;
						end else begin
							move = 1'b1;
							re_a = 1'b1;
							re_b = 1'b1;
							ra   = nxt.left;
							rb   = nxt.right;
						end
					end
				end
			end
			ST_FETCH_NODE: begin
				re_a = 1'b1;
				re_b = 1'b1;
				ra   = walk_q;
				rb   = root_q;
			end
			ST_FETCH_ROOT_KIDS: begin
				re_a = 1'b1;
				re_b = 1'b1;
				ra   = rd_b_q.left;
				rb   = rd_b_q.right;
			end
			ST_FETCH_CUR_KIDS: begin
				re_a = 1'b1;
				re_b = 1'b1;
				ra   = cur_q.left;
				rb   = cur_q.right;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[head.addr] <= head.node;
		end
		if (re_a) begin
			rd_a_q <= mem[ra];
		end
		if (re_b) begin
			rd_b_q <= mem[rb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			stale_q     <= 1'b1;
			root_q      <= '0;
			walk_q      <= '0;
			kids_mem_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we || we) begin
				stale_q <= 1'b1;
			end else if (state_q == ST_FETCH_CUR_KIDS) begin
				stale_q <= 1'b0;
			end
			if (cfg_we) begin
				root_q <= root_node;
			end
			if (cfg_we) begin
				walk_q <= root_node;
			end else if (restart) begin
				walk_q <= root_q;
			end else if (move) begin
				walk_q <= child;
			end
			if (restart) begin
				kids_mem_q <= 1'b0;
			end else if (move || state_q == ST_FETCH_CUR_KIDS) begin
				kids_mem_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH_ROOT_KIDS) begin
			cur_q      <= rd_a_q;
			root_ent_q <= rd_b_q;
		end else if (restart) begin
			cur_q <= root_ent_q;
		end else if (move) begin
			cur_q <= nxt;
		end
		if (state_q == ST_FETCH_CUR_KIDS) begin
			rl_q <= rd_a_q;
			rr_q <= rd_b_q;
		end
		if (emit) begin
			out_sym_q <= emit_sym;
		end
	end

	`ASSERT_NEVER(a_pop_in_refresh, clk, arst_n, (state_q != ST_RUN) && pop)
	`ASSERT_PROP(a_refresh_done, clk, arst_n, (state_q == ST_FETCH_CUR_KIDS) |=> (state_q == ST_RUN && !stale_q))
	`ASSERT_PROP(a_emit_fresh, clk, arst_n, emit |-> (state_q == ST_RUN && !stale_q && !head.is_load))
	`ASSERT_PROP(a_cfg_restart, clk, arst_n, cfg_we |=> (stale_q && walk_q == root_q))

endmodule

// ===== sv/huffman_bit_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_bit_decoder
// Huffman decoder walking a code tree held in a node table, one bit per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): cmd selects a load (writes node_addr with
// left_child, right_child, leaf_flag, leaf_symbol) or a decode (code_bit).
// Output channel (out_valid/out_stall) carries decoded_symbol, one transfer
// each time the walk reaches a leaf; loads and inner-node bits give nothing.
// Config channel (cfg_valid/cfg_ready) writes root_node and restarts the walk;
// write it only while the block is idle.
// A result passes from the front register through the queue to the output
// register. Throughput is one item per cycle unless the walker refetches or
// out_stall holds the result: the walker holds the current node's two children
// in registers and fetches the next pair on the two read ports of the table.
// The first decode after reset, after a root write or after any loads waits
// while the walker refetches the current node, the root and their children.
// Reset empties the queue, sets root and walk to node 0; the table is not
// cleared. When out_stall holds the result, the queue keeps taking input until
// it fills, then in_stall rises.
// ----------------------------------------------------------------------------
module huffman_bit_decoder import hbd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   cmd,
	input  logic [FIELD_IDX_W-1:0] node_addr,
	input  logic [FIELD_IDX_W-1:0] left_child,
	input  logic [FIELD_IDX_W-1:0] right_child,
	input  logic                   leaf_flag,
	input  logic [7:0]             leaf_symbol,
	input  logic                   code_bit,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [OUT_W-1:0]       decoded_symbol,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [FIELD_IDX_W-1:0] root_node
);

	logic         op_valid;
	op_t          op;
	op_t          head;
	fifo_status_t fifo_st;
	logic         pop;

	hbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.node_addr   (node_addr),
		.left_child  (left_child),
		.right_child (right_child),
		.leaf_flag   (leaf_flag),
		.leaf_symbol (leaf_symbol),
		.code_bit    (code_bit),
		.fifo_st     (fifo_st),
		.op_valid    (op_valid),
		.op          (op)
	);

	hbd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (op_valid),
		.push_op    (op),
		.pop        (pop),
		.head       (head),
		.st         (fifo_st)
	);

	hbd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.fifo_st        (fifo_st),
		.pop            (pop),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.root_node      (root_node[IDX_W-1:0]),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.decoded_symbol (decoded_symbol)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bit_decoder testbench
// Loads code trees into the node table and streams code bits through them.
// A bit-level predictor walks its own copy of the table and queues the
// symbols due. The monitor compares every output transfer with them in
// order. Both channels idle and stall at random, with up to three long output
// holds and an explicit drain. The root register is written only while the
// block is idle.
// ----------------------------------------------------------------------------
module testbench;
	import hbd_pkg::*;

	localparam int SETTLE_CYCLES  = 24;
	localparam int LONG_HOLD      = 100;
	localparam int TAIL_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 850;

	typedef enum logic [1:0] {STEP_ITEM, STEP_ROOT, STEP_DRAIN} step_kind_e;

	typedef struct packed {
		step_kind_e kind;
		logic       cmd;
		idx_t       addr;
		node_t      node;
		logic       code_bit;
	} stim_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   in_valid    = 1'b0;
	logic                   in_stall;
	logic                   cmd         = CMD_LOAD;
	logic [FIELD_IDX_W-1:0] node_addr   = '0;
	logic [FIELD_IDX_W-1:0] left_child  = '0;
	logic [FIELD_IDX_W-1:0] right_child = '0;
	logic                   leaf_flag   = 1'b0;
	logic [7:0]             leaf_symbol = '0;
	logic                   code_bit    = 1'b0;
	logic                   out_valid;
	logic                   out_stall   = 1'b0;
	logic [OUT_W-1:0]       decoded_symbol;
	logic                   cfg_valid   = 1'b0;
	logic                   cfg_ready;
	logic [FIELD_IDX_W-1:0] root_node   = '0;

	huffman_bit_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.node_addr(node_addr),
		.left_child(left_child),
		.right_child(right_child),
		.leaf_flag(leaf_flag),
		.leaf_symbol(leaf_symbol),
		.code_bit(code_bit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.decoded_symbol(decoded_symbol),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.root_node(root_node)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// stimulus generation state
	stim_t stim_q[$];
	bit    gen_written[NODE_COUNT];
	int    gen_list[$];
	bit    in_tree[NODE_COUNT];
	int    tree_members[$];
	int    gen_count = 0;

	// predictor state
	node_t            tree_tab[NODE_COUNT];
	idx_t             root_idx = '0;
	idx_t             walk_at  = '0;
	logic             at_root  = 1'b1;
	logic [OUT_W-1:0] symbols_due[$];

	int mismatches      = 0;
	int loads_seen      = 0;
	int decodes_seen    = 0;
	int symbols_checked = 0;
	int roots_seen      = 0;
	int long_holds      = 0;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic int pick_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic int pick_written();
		return gen_list[$urandom_range(0, gen_list.size() - 1)];
	endfunction

	task automatic add_load(input int a, input int l, input int r, input logic lf, input int sym);
		stim_t s;
		s.kind      = STEP_ITEM;
		s.cmd       = CMD_LOAD;
		s.addr      = idx_t'(a);
		s.node.left = idx_t'(l);
		s.node.right = idx_t'(r);
		s.node.leaf = lf;
		s.node.sym  = sym[SYMBOL_BITS-1:0];
		s.code_bit  = 1'($urandom_range(0, 1));
		stim_q.push_back(s);
		gen_count++;
		if (!gen_written[a]) begin
			gen_written[a] = 1'b1;
			gen_list.push_back(a);
		end
	endtask

	task automatic add_bit(input logic b);
		stim_t s;
		s.kind       = STEP_ITEM;
		s.cmd        = CMD_DECODE;
		s.addr       = idx_t'($urandom_range(0, NODE_COUNT - 1));
		s.node.left  = idx_t'($urandom_range(0, NODE_COUNT - 1));
		s.node.right = idx_t'($urandom_range(0, NODE_COUNT - 1));
		s.node.leaf  = 1'($urandom_range(0, 1));
		s.node.sym   = SYMBOL_BITS'($urandom_range(0, 255));
		s.code_bit   = b;
		stim_q.push_back(s);
		gen_count++;
	endtask

	task automatic add_marker(input step_kind_e k, input int r);
		stim_t s;
		s      = '0;
		s.kind = k;
		s.addr = idx_t'(r);
		stim_q.push_back(s);
	endtask

	function automatic int fresh_tree_addr();
		int a;
		do
			a = $urandom_range(0, NODE_COUNT - 1);
		while (in_tree[a]);
		in_tree[a] = 1'b1;
		tree_members.push_back(a);
		return a;
	endfunction

	// bottom-up build: every child is written before its parent, so the
	// table never points at an entry that was never loaded
	task automatic build_tree(input int leaves, output int top);
		int pool[$];
		int a, i, l, r;
		foreach (in_tree[k])
			in_tree[k] = 1'b0;
		tree_members.delete();
		for (i = 0; i < leaves; i++) begin
			a = fresh_tree_addr();
			add_load(a, pick_written(), pick_written(), 1'b1, $urandom_range(0, 255));
			pool.push_back(a);
		end
		while (pool.size() > 1) begin
			i = $urandom_range(0, pool.size() - 1);
			l = pool[i];
			pool.delete(i);
			i = $urandom_range(0, pool.size() - 1);
			r = pool[i];
			pool.delete(i);
			a = fresh_tree_addr();
			add_load(a, l, r, 1'b0, $urandom_range(0, 255));
			pool.push_back(a);
		end
		top = pool[0];
	endtask

	function automatic void walk_one_bit(input logic b);
		node_t here;
		node_t next_n;
		idx_t  child;
		here = tree_tab[walk_at];
		if (here.leaf) begin
			symbols_due.push_back(here.sym);
			walk_at = root_idx;
			at_root = 1'b1;
		end else begin
			child  = b ? here.right : here.left;
			next_n = tree_tab[child];
			if (next_n.leaf) begin
				symbols_due.push_back(next_n.sym);
				walk_at = root_idx;
				at_root = 1'b1;
			end else begin
				walk_at = child;
				at_root = 1'b0;
			end
		end
	endfunction

	// driver
	int tx_wait = 0;
	int settle  = 0;
	bit tx_calm = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
			tx_wait   <= 0;
			settle    <= 0;
		end else begin
			if ((in_valid && !in_stall) || symbols_due.size() != 0 || out_valid)
				settle <= 0;
			else if (settle < SETTLE_CYCLES)
				settle <= settle + 1;

			if (!(in_valid && in_stall) && !(cfg_valid && !cfg_ready)) begin
				if (tx_wait != 0) begin
					in_valid  <= 1'b0;
					cfg_valid <= 1'b0;
					tx_wait   <= tx_wait - 1;
				end else if (stim_q.size() == 0) begin
					in_valid  <= 1'b0;
					cfg_valid <= 1'b0;
				end else if (stim_q[0].kind == STEP_ITEM) begin
					in_valid    <= 1'b1;
					cfg_valid   <= 1'b0;
					cmd         <= stim_q[0].cmd;
					node_addr   <= stim_q[0].addr;
					left_child  <= stim_q[0].node.left;
					right_child <= stim_q[0].node.right;
					leaf_flag   <= stim_q[0].node.leaf;
					leaf_symbol <= stim_q[0].node.sym;
					code_bit    <= stim_q[0].code_bit;
					void'(stim_q.pop_front());
					tx_wait <= pick_wait(tx_calm);
					if ($urandom_range(0, 39) == 0)
						tx_calm <= !tx_calm;
				end else if (settle == SETTLE_CYCLES) begin
					in_valid <= 1'b0;
					if (stim_q[0].kind == STEP_ROOT) begin
						cfg_valid <= 1'b1;
						root_node <= stim_q[0].addr;
					end else begin
						cfg_valid <= 1'b0;
					end
					void'(stim_q.pop_front());
				end else begin
					in_valid  <= 1'b0;
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	int rx_left = 0;
	int hold_left = 0;
	int rx_seen = 0;
	bit rx_calm = 1'b0;

	always @(posedge clk) begin
		int n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_left   <= 0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (out_valid && !out_stall) begin
			rx_seen <= rx_seen + 1;
			if (rx_seen == 30 || rx_seen == 200 || rx_seen == 450) begin
				out_stall  <= 1'b1;
				hold_left  <= LONG_HOLD;
				long_holds <= long_holds + 1;
			end else begin
				n = pick_wait(rx_calm);
				out_stall <= (n != 0);
				rx_left   <= (n > 0) ? n - 1 : 0;
				if ($urandom_range(0, 29) == 0)
					rx_calm <= !rx_calm;
			end
		end else if (rx_left != 0) begin
			out_stall <= 1'b1;
			rx_left   <= rx_left - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// predictor and checker
	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				root_idx = root_node;
				walk_at  = root_node;
				at_root  = 1'b1;
				roots_seen++;
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_LOAD) begin
					tree_tab[node_addr] = {left_child, right_child, leaf_flag, leaf_symbol};
					loads_seen++;
				end else begin
					walk_one_bit(code_bit);
					decodes_seen++;
				end
			end
			if (out_valid && !out_stall) begin
				if (symbols_due.size() == 0) begin
					report_mismatch($sformatf("symbol %02h with none due", decoded_symbol));
				end else begin
					want = symbols_due.pop_front();
					if (decoded_symbol !== want)
						report_mismatch($sformatf("decoded_symbol %02h, want %02h",
							decoded_symbol, want));
					symbols_checked++;
				end
			end
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int top, leaves, n, i, a, r, directed_end;
		bit drained;
		foreach (tree_tab[k])
			tree_tab[k] = '0;

		// root leaf, extremes, walk landing on a rewritten leaf, load mid-walk
		add_load(0, 0, 0, 1'b1, 8'h00);
		add_bit(1'b0);
		add_bit(1'b1);
		add_load(511, 511, 511, 1'b1, 8'hFF);
		add_load(1, 0, 511, 1'b1, 8'hA5);
		add_load(2, 1, 511, 1'b0, 8'h5A);
		add_marker(STEP_ROOT, 511);
		add_bit(1'b1);
		add_load(0, 2, 511, 1'b0, 8'h00);
		add_marker(STEP_ROOT, 0);
		add_bit(1'b1);
		add_bit(1'b0);
		add_bit(1'b0);
		add_bit(1'b0);
		add_bit(1'b1);
		add_bit(1'b0);
		add_load(2, 0, 511, 1'b1, 8'h3C);
		add_bit(1'b1);
		add_bit(1'b0);
		add_load(2, 1, 511, 1'b0, 8'h5A);
		add_bit(1'b0);
		add_load(300, 0, 0, 1'b1, 8'h77);
		add_bit(1'b0);
		directed_end = gen_count;

		drained = 1'b0;
		while (gen_count < directed_end + RANDOM_ITEMS) begin
			r = $urandom_range(0, 19);
			leaves = (r == 0) ? 1 : (r == 1) ? 30 : $urandom_range(2, 10);
			build_tree(leaves, top);
			add_marker(STEP_ROOT, top);
			n = $urandom_range(20, 60);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 11) == 0) begin
					if ($urandom_range(0, 1)) begin
						a = tree_members[$urandom_range(0, tree_members.size() - 1)];
						add_load(a, pick_written(), pick_written(), 1'b1,
							$urandom_range(0, 255));
					end else begin
						a = $urandom_range(0, NODE_COUNT - 1);
						add_load(a, pick_written(), pick_written(), in_tree[a],
							$urandom_range(0, 255));
					end
				end
				add_bit(1'($urandom_range(0, 1)));
			end
			if (!drained && gen_count > directed_end + RANDOM_ITEMS / 2) begin
				add_marker(STEP_DRAIN, 0);
				drained = 1'b1;
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || in_valid || cfg_valid || symbols_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d node loads and %0d code bits under %0d root settings",
			loads_seen, decodes_seen, roots_seen);
		$display("compared %0d symbols, %0d long output holds", symbols_checked, long_holds);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/hbd_pkg.sv
sv/hbd_front.sv
sv/hbd_fifo.sv
sv/hbd_back.sv
sv/huffman_bit_decoder.sv
dv/testbench.sv
